FILE: rtl/ctc_pkg.sv
package ctc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    localparam logic [SEC_W:0]    SECS_PER_MIN  = 7'd60;
    localparam logic [MIN_W:0]    MINS_PER_HOUR = 7'd60;
    localparam logic [HOUR_W:0]   HOURS_PER_DAY = 6'd24;
    localparam logic [HOUR_W-1:0] HOUR_NOON     = 5'd12;
    localparam logic [HOUR_W-1:0] HOUR_MIDNIGHT = 5'd0;

    localparam logic [YEAR_W-1:0]  YEAR_LAST     = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_AT_RESET = 14'd2018;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR     = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN     = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP     = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV     = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;

    // Division by 100 of a 14-bit year: multiply by ceil(2^19 / 100) and shift.
    // The error stays below 1/100 for every year below 2^14.
    localparam int             DIV100_SHIFT = 19;
    localparam int             PROD_W       = YEAR_W + 13;
    localparam int             CENT_W       = PROD_W - DIV100_SHIFT;
    localparam logic [12:0]    DIV100_MUL   = 13'd5243;
    localparam logic [YEAR_W:0] CENTURY     = 15'd100;

    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_ctc_load;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_ctc_time;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_ctc_date;

    typedef struct packed {
        logic accept;
        logic load;
    } t_ctc_step;

    typedef struct packed {
        logic               pad;
        logic               day_rolled;
        logic               is_pm;
        logic [HOUR_W-1:0]  shown_hour;
        logic [SEC_W-1:0]   cur_second;
        logic [MIN_W-1:0]   cur_minute;
        logic [HOUR_W-1:0]  cur_hour;
        logic [DAY_W-1:0]   cur_day;
        logic [MONTH_W-1:0] cur_month;
        logic [YEAR_W-1:0]  cur_year;
    } t_ctc_result;

    // Gregorian rule: divisible by 4, except by 100, unless by 400.
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [CENT_W-1:0] cent;
        logic [YEAR_W:0]   back;
        prod = PROD_W'(y) * PROD_W'(DIV100_MUL);
        cent = prod[PROD_W-1:DIV100_SHIFT];
        back = (YEAR_W + 1)'(cent) * CENTURY;
        return (y[1:0] == 2'd0) && ((back[YEAR_W-1:0] != y) || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_FEB: begin
                len = leap ? 5'd29 : 5'd28;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/ctc_time.sv
module ctc_time (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ctc_pkg::t_ctc_step   i_step,
    input  ctc_pkg::t_ctc_time   i_load,
    output ctc_pkg::t_ctc_time   o_next,
    output logic                 o_roll
);

    ctc_pkg::t_ctc_time r_time;
    ctc_pkg::t_ctc_time n_time;

    logic [ctc_pkg::SEC_W:0]  sec_inc;
    logic [ctc_pkg::MIN_W:0]  min_val;
    logic [ctc_pkg::HOUR_W:0] hour_val;
    logic                     roll;

    // Seconds carry into minutes, minutes into hours; an hour past the day wraps.
    always_comb begin
        n_time   = r_time;
        roll     = 1'b0;
        sec_inc  = {1'b0, r_time.second} + 7'd1;
        min_val  = {1'b0, r_time.minute};
        hour_val = {1'b0, r_time.hour};
        if (i_step.load) begin
            n_time = i_load;
        end else begin
            if (sec_inc >= ctc_pkg::SECS_PER_MIN) begin
                n_time.second = '0;
                min_val       = min_val + 7'd1;
            end else begin
                n_time.second = sec_inc[ctc_pkg::SEC_W-1:0];
            end
            if (min_val >= ctc_pkg::MINS_PER_HOUR) begin
                n_time.minute = '0;
                hour_val      = hour_val + 6'd1;
            end else begin
                n_time.minute = min_val[ctc_pkg::MIN_W-1:0];
            end
            if (hour_val >= ctc_pkg::HOURS_PER_DAY) begin
                n_time = '0;
                roll   = 1'b1;
            end else begin
                n_time.hour = hour_val[ctc_pkg::HOUR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_step.accept) begin
            r_time <= n_time;
        end
    end

    assign o_next = n_time;
    assign o_roll = roll;

endmodule

FILE: rtl/ctc_date.sv
module ctc_date (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ctc_pkg::t_ctc_step   i_step,
    input  ctc_pkg::t_ctc_date   i_load,
    input  logic                 i_roll,
    output ctc_pkg::t_ctc_date   o_next
);

    ctc_pkg::t_ctc_date r_date;
    ctc_pkg::t_ctc_date n_date;
    logic               r_leap;
    logic               n_leap;
    logic [ctc_pkg::DAY_W-1:0] len;

    // The leap flag travels with the year so the month length is ready at once.
    always_comb begin
        n_date = r_date;
        len    = ctc_pkg::month_length(r_date.month, r_leap);
        if (i_step.load) begin
            n_date = i_load;
        end else if (i_roll) begin
            if (r_date.day < len) begin
                n_date.day = r_date.day + 5'd1;
            end else begin
                n_date.day = ctc_pkg::DAY_FIRST;
                if (r_date.month >= ctc_pkg::MONTH_DEC) begin
                    n_date.month = ctc_pkg::MONTH_JAN;
                    n_date.year  = (r_date.year >= ctc_pkg::YEAR_LAST) ? '0
                                 : r_date.year + 14'd1;
                end else begin
                    n_date.month = r_date.month + 4'd1;
                end
            end
        end
        n_leap = ctc_pkg::leap_year(n_date.year);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date.year  <= ctc_pkg::YEAR_AT_RESET;
            r_date.month <= ctc_pkg::MONTH_JAN;
            r_date.day   <= ctc_pkg::DAY_FIRST;
            r_leap       <= 1'b0;
        end else if (i_step.accept) begin
            r_date <= n_date;
            r_leap <= n_leap;
        end
    end

    assign o_next = n_date;

endmodule

FILE: rtl/ctc_disp.sv
module ctc_disp (
    input  logic [ctc_pkg::HOUR_W-1:0] i_hour,
    input  logic                       i_fmt_12h,
    output logic [ctc_pkg::HOUR_W-1:0] o_shown_hour,
    output logic                       o_is_pm
);

    // In 12-hour form midnight shows as 12 and afternoon hours drop by 12.
    always_comb begin
        o_shown_hour = i_hour;
        o_is_pm      = 1'b0;
        if (i_fmt_12h) begin
            if (i_hour == ctc_pkg::HOUR_MIDNIGHT) begin
                o_shown_hour = ctc_pkg::HOUR_NOON;
            end else if (i_hour > ctc_pkg::HOUR_NOON) begin
                o_shown_hour = i_hour - ctc_pkg::HOUR_NOON;
            end
            o_is_pm = (i_hour >= ctc_pkg::HOUR_NOON);
        end
    end

endmodule

FILE: rtl/clock_calendar_tick.sv
// Real-time clock and calendar driven by a stream of one-second ticks.
// Input channel (s_axis): each transfer is a tick (tuser 0) or a load of the
// whole time and date (tuser 1, values in tdata, stored without any range check).
// Output channel (m_axis): every input transfer yields exactly one result with
// the year, month, day and 24-hour time after that step, the displayed hour,
// the PM flag and a flag that marks a tick that crossed midnight.
// Configuration: i_cfg_we writes i_cfg_wdata into the hour-format register
// (0 gives a 24-hour displayed hour, 1 gives 12-hour with PM flag); write it
// only while no transfer is in flight.
// A result appears on m_axis in the cycle after its input transfer. Throughput is
// one item per cycle while the receiver does not stall, set by the registered update of
// the time and date registers, which the next item reads straight away.
// The result register frees the input side: a new item is taken while the
// receiver takes the previous result in the same cycle. When the receiver
// stalls, the held result stays on m_axis and s_axis_tready drops until it is
// taken. Reset (synchronous, active low) sets 00:00:00 on January 1, 2018,
// selects the 24-hour format and empties the result register.
module clock_calendar_tick (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: load_year, load_month, load_day, load_hour,
    // load_minute, load_second
    input  logic [ctc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: action (0 tick, 1 load)
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0: cur_year, cur_month, cur_day, cur_hour, cur_minute,
    // cur_second, shown_hour, is_pm, day_rolled, one zero pad bit
    output logic [ctc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic                 r_hour_format;
    logic                 r_out_valid;
    ctc_pkg::t_ctc_result r_result;
    ctc_pkg::t_ctc_result n_result;

    ctc_pkg::t_ctc_load   load_in;
    ctc_pkg::t_ctc_time   load_time;
    ctc_pkg::t_ctc_date   load_date;
    ctc_pkg::t_ctc_step   step;
    ctc_pkg::t_ctc_time   next_time;
    ctc_pkg::t_ctc_date   next_date;
    logic                 roll;
    logic                 accept;
    logic [ctc_pkg::HOUR_W-1:0] shown_hour;
    logic                 is_pm;

    // The input side is open whenever the result register is empty or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign load_in          = ctc_pkg::t_ctc_load'(s_axis_tdata);
    assign load_time.hour   = load_in.hour;
    assign load_time.minute = load_in.minute;
    assign load_time.second = load_in.second;
    assign load_date.year   = load_in.year;
    assign load_date.month  = load_in.month;
    assign load_date.day    = load_in.day;

    assign step.accept = accept;
    assign step.load   = s_axis_tuser;

    ctc_time u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_load  (load_time),
        .o_next  (next_time),
        .o_roll  (roll)
    );

    ctc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_load  (load_date),
        .i_roll  (roll),
        .o_next  (next_date)
    );

    ctc_disp u_disp (
        .i_hour       (next_time.hour),
        .i_fmt_12h    (r_hour_format),
        .o_shown_hour (shown_hour),
        .o_is_pm      (is_pm)
    );

    // The result carries the state after this step, the same values the
    // counters take at this edge.
    always_comb begin
        n_result.pad        = 1'b0;
        n_result.day_rolled = roll;
        n_result.is_pm      = is_pm;
        n_result.shown_hour = shown_hour;
        n_result.cur_second = next_time.second;
        n_result.cur_minute = next_time.minute;
        n_result.cur_hour   = next_time.hour;
        n_result.cur_day    = next_date.day;
        n_result.cur_month  = next_date.month;
        n_result.cur_year   = next_date.year;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_format <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hour_format <= i_cfg_wdata;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result;

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted transfer did not produce a result");

    a_load_never_rolls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tuser |=> !r_result.day_rolled)
        else $error("load reported a midnight rollover");

    a_roll_at_midnight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.day_rolled |->
            (r_result.cur_hour == '0) && (r_result.cur_minute == '0)
            && (r_result.cur_second == '0))
        else $error("rollover result not at midnight");

    a_tick_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !s_axis_tuser && !roll |=>
            (r_result.cur_day == $past(r_result.cur_day)) || !$past(r_out_valid))
        else $error("date changed on a tick without rollover");
`endif

endmodule
